// File: sv/caldc_pkg.sv
`default_nettype none

package caldc_pkg;

    // year limits of the counter
    localparam logic [13:0] YEAR_MIN = 14'd1;
    localparam logic [13:0] YEAR_MAX = 14'd9999;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    localparam logic [4:0] DAY_FIRST    = 5'd1;
    localparam logic [4:0] DAY_DEC_LAST = 5'd31;

    // reset date
    localparam logic [4:0]  RESET_DAY   = 5'd1;
    localparam logic [3:0]  RESET_MONTH = 4'd1;
    localparam logic [13:0] RESET_YEAR  = 14'd2000;

    // floor(y / 100) as (y * 5243) >> 19, exact for y below 12800 (7-bit quotient)
    localparam int          DIV100_SHIFT = 19;
    localparam logic [12:0] DIV100_MAGIC = 13'd5243;

    localparam logic [2:0] WD_FRI = 3'd5;
    localparam logic [2:0] WD_SAT = 3'd6;

    typedef enum logic [2:0] {
        OP_NEXT_DAY   = 3'd0,
        OP_PREV_DAY   = 3'd1,
        OP_NEXT_MONTH = 3'd2,
        OP_PREV_MONTH = 3'd3,
        OP_LOAD       = 3'd4
    } t_op;

    typedef struct packed {
        logic [2:0]  operation;
        logic [4:0]  load_day;
        logic [3:0]  load_month;
        logic [13:0] load_year;
    } t_in_word;

    typedef struct packed {
        logic [4:0]  day_out;
        logic [3:0]  month_out;
        logic [13:0] year_out;
        logic [2:0]  weekday;
        logic [8:0]  day_of_year;
        logic        leap_flag;
        logic        weekend_flag;
        logic        month_end_flag;
        logic        load_error;
    } t_out_word;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
    } t_date;

    // partial weekday terms handed to the last stage
    typedef struct packed {
        t_date       date;
        logic        err;
        logic        leap;
        logic [13:0] yp;
        logic [6:0]  q100;
    } t_wd_parts;

    function automatic logic [26:0] f_mul100(input logic [13:0] y);
        return 27'(y) * 27'(DIV100_MAGIC);
    endfunction

    function automatic logic [6:0] f_div100(input logic [13:0] y);
        logic [26:0] p;
        p = f_mul100(y);
        return p[25:DIV100_SHIFT];
    endfunction

    // multiples of 100 leave a fraction below the magic constant
    function automatic logic f_is_leap(input logic [13:0] y);
        logic [26:0] p;
        logic        div100;
        logic [6:0]  q;
        p      = f_mul100(y);
        div100 = (p[DIV100_SHIFT-1:0] < 19'(DIV100_MAGIC));
        q      = p[25:DIV100_SHIFT];
        return div100 ? (q[1:0] == 2'd0) : (y[1:0] == 2'd0);
    endfunction

    function automatic logic [4:0] f_days_in(input logic [3:0] m, input logic leap);
        logic [4:0] r;
        case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
            4'd2:                                       r = leap ? 5'd29 : 5'd28;
            default:                                    r = 5'd0;
        endcase
        return r;
    endfunction

    function automatic logic [8:0] f_days_before(input logic [3:0] m);
        logic [8:0] r;
        case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // 31 * mm / 12 with march as month one
    function automatic logic [4:0] f_month_offset(input logic [3:0] m);
        logic [4:0] r;
        case (m)
            4'd1:    r = 5'd28;
            4'd2:    r = 5'd31;
            4'd3:    r = 5'd2;
            4'd4:    r = 5'd5;
            4'd5:    r = 5'd7;
            4'd6:    r = 5'd10;
            4'd7:    r = 5'd12;
            4'd8:    r = 5'd15;
            4'd9:    r = 5'd18;
            4'd10:   r = 5'd20;
            4'd11:   r = 5'd23;
            4'd12:   r = 5'd25;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    // 8 = 1 mod 7, so octal digits fold down
    function automatic logic [2:0] f_mod7(input logic [14:0] s);
        logic [5:0] t1;
        logic [3:0] t2;
        t1 = 6'(s[2:0]) + 6'(s[5:3]) + 6'(s[8:6]) + 6'(s[11:9]) + 6'(s[14:12]);
        t2 = 4'(t1[2:0]) + 4'(t1[5:3]);
        return (t2 >= 4'd7) ? 3'(t2 - 4'd7) : t2[2:0];
    endfunction

endpackage

`default_nettype wire

// File: sv/calendar_date_counter.sv
// channel   direction  handshake                    word
// in        input      i_in_valid / o_in_ready      i_in_data  (caldc_pkg::t_in_word)
// out       output     o_out_valid / i_out_ready    o_out_data (caldc_pkg::t_out_word)
//
// one word per cycle while o_in_ready is high; result via p1, p2, out registers
// the date registers are updated in the accept cycle, so back-to-back words chain
// latency is set by the weekday path: div-by-100 multiply, then digit-fold mod 7
// a stalled output holds its word; empty stages still absorb new words
// synchronous active-low reset restores 1 jan 2000 and empties the pipeline

`default_nettype none

module calendar_date_counter (
    input  var logic                 i_clk,
    input  var logic                 i_rst_n,
    input  var logic                 i_in_valid,
    output logic                     o_in_ready,
    input  var caldc_pkg::t_in_word  i_in_data,
    output logic                     o_out_valid,
    input  var logic                 i_out_ready,
    output caldc_pkg::t_out_word     o_out_data
);

    // current date, always a valid calendar date
    caldc_pkg::t_date r_date;
    caldc_pkg::t_date n_date;
    logic             n_err;

    // stage 1: updated date and error flag
    logic             r_p1_valid;
    caldc_pkg::t_date r_p1_date;
    logic             r_p1_err;

    // stage 2: weekday terms
    logic                 r_p2_valid;
    caldc_pkg::t_wd_parts r_p2;
    caldc_pkg::t_wd_parts n_p2;

    // output register
    logic                 r_out_valid;
    caldc_pkg::t_out_word r_out_data;
    caldc_pkg::t_out_word n_out_data;

    logic en_out;
    logic en_p2;
    logic en_p1;
    logic accept;
    logic jan_feb;

    // stage enables, a bubble anywhere lets upstream move
    assign en_out     = !r_out_valid || i_out_ready;
    assign en_p2      = !r_p2_valid || en_out;
    assign en_p1      = !r_p1_valid || en_p2;
    assign o_in_ready = en_p1;
    assign accept     = i_in_valid && en_p1;

    // next date from current date and incoming word
    caldc_step u_step (
        .i_date (r_date),
        .i_word (i_in_data),
        .o_date (n_date),
        .o_err  (n_err)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_date.day   <= caldc_pkg::RESET_DAY;
            r_date.month <= caldc_pkg::RESET_MONTH;
            r_date.year  <= caldc_pkg::RESET_YEAR;
        end else if (accept) begin
            r_date <= n_date;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else if (en_p1) begin
            r_p1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p1_date <= n_date;
            r_p1_err  <= n_err;
        end
    end

    // january and february count as months of the previous year
    always_comb begin
        jan_feb     = (r_p1_date.month <= caldc_pkg::MONTH_FEB);
        n_p2.date   = r_p1_date;
        n_p2.err    = r_p1_err;
        n_p2.leap   = caldc_pkg::f_is_leap(r_p1_date.year);
        n_p2.yp     = r_p1_date.year - 14'(jan_feb);
        n_p2.q100   = caldc_pkg::f_div100(n_p2.yp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_valid <= 1'b0;
        end else if (en_p2) begin
            r_p2_valid <= r_p1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_p2 && r_p1_valid) begin
            r_p2 <= n_p2;
        end
    end

    // weekday, day of year and flags
    caldc_facts u_facts (
        .i_parts (r_p2),
        .o_word  (n_out_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= r_p2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out && r_p2_valid) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// File: sv/caldc_step.sv
`default_nettype none

module caldc_step (
    input  var caldc_pkg::t_date    i_date,
    input  var caldc_pkg::t_in_word i_word,
    output caldc_pkg::t_date        o_date,
    output logic                    o_err
);

    logic       leap_cur;
    logic       leap_ld;
    logic [4:0] dim_cur;
    logic [4:0] dim_prev;
    logic [4:0] dim_next;
    logic [4:0] dim_ld;
    logic [3:0] prev_m;
    logic [3:0] next_m;
    logic       ld_ok;

    always_comb begin
        leap_cur = caldc_pkg::f_is_leap(i_date.year);
        leap_ld  = caldc_pkg::f_is_leap(i_word.load_year);
        prev_m   = i_date.month - 4'd1;
        next_m   = i_date.month + 4'd1;
        dim_cur  = caldc_pkg::f_days_in(i_date.month, leap_cur);
        dim_prev = caldc_pkg::f_days_in(prev_m, leap_cur);
        dim_next = caldc_pkg::f_days_in(next_m, leap_cur);
        dim_ld   = caldc_pkg::f_days_in(i_word.load_month, leap_ld);
        ld_ok    = (i_word.load_month inside {[caldc_pkg::MONTH_JAN:caldc_pkg::MONTH_DEC]})
                && (i_word.load_day != 5'd0) && (i_word.load_day <= dim_ld)
                && (i_word.load_year inside {[caldc_pkg::YEAR_MIN:caldc_pkg::YEAR_MAX]});

        o_date = i_date;
        o_err  = 1'b0;

        case (caldc_pkg::t_op'(i_word.operation))
            caldc_pkg::OP_NEXT_DAY: begin
                if (i_date.day >= dim_cur) begin
                    if (i_date.month == caldc_pkg::MONTH_DEC) begin
                        if (i_date.year >= caldc_pkg::YEAR_MAX) begin
                            o_err = 1'b1;
                        end else begin
                            o_date.day   = caldc_pkg::DAY_FIRST;
                            o_date.month = caldc_pkg::MONTH_JAN;
                            o_date.year  = i_date.year + 14'd1;
                        end
                    end else begin
                        o_date.day   = caldc_pkg::DAY_FIRST;
                        o_date.month = next_m;
                    end
                end else begin
                    o_date.day = i_date.day + 5'd1;
                end
            end
            caldc_pkg::OP_PREV_DAY: begin
                if (i_date.day <= caldc_pkg::DAY_FIRST) begin
                    if (i_date.month == caldc_pkg::MONTH_JAN) begin
                        if (i_date.year <= caldc_pkg::YEAR_MIN) begin
                            o_err = 1'b1;
                        end else begin
                            o_date.day   = caldc_pkg::DAY_DEC_LAST;
                            o_date.month = caldc_pkg::MONTH_DEC;
                            o_date.year  = i_date.year - 14'd1;
                        end
                    end else begin
                        o_date.day   = dim_prev;
                        o_date.month = prev_m;
                    end
                end else begin
                    o_date.day = i_date.day - 5'd1;
                end
            end
            caldc_pkg::OP_NEXT_MONTH: begin
                // december and january both have 31 days, no clamp on year change
                if (i_date.month == caldc_pkg::MONTH_DEC) begin
                    if (i_date.year >= caldc_pkg::YEAR_MAX) begin
                        o_err = 1'b1;
                    end else begin
                        o_date.month = caldc_pkg::MONTH_JAN;
                        o_date.year  = i_date.year + 14'd1;
                    end
                end else begin
                    o_date.month = next_m;
                    if (i_date.day > dim_next) begin
                        o_date.day = dim_next;
                    end
                end
            end
            caldc_pkg::OP_PREV_MONTH: begin
                if (i_date.month == caldc_pkg::MONTH_JAN) begin
                    if (i_date.year <= caldc_pkg::YEAR_MIN) begin
                        o_err = 1'b1;
                    end else begin
                        o_date.month = caldc_pkg::MONTH_DEC;
                        o_date.year  = i_date.year - 14'd1;
                    end
                end else begin
                    o_date.month = prev_m;
                    if (i_date.day > dim_prev) begin
                        o_date.day = dim_prev;
                    end
                end
            end
            caldc_pkg::OP_LOAD: begin
                if (ld_ok) begin
                    o_date.day   = i_word.load_day;
                    o_date.month = i_word.load_month;
                    o_date.year  = i_word.load_year;
                end else begin
                    o_err = 1'b1;
                end
            end
            default: begin
                o_date = i_date;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/caldc_facts.sv
`default_nettype none

module caldc_facts (
    input  var caldc_pkg::t_wd_parts i_parts,
    output caldc_pkg::t_out_word     o_word
);

    logic [14:0] wd_sum;
    logic [2:0]  wd;
    logic [4:0]  dim;
    logic        after_feb;

    always_comb begin
        wd_sum = 15'(i_parts.date.day) + 15'(i_parts.yp) + 15'(i_parts.yp[13:2])
               + 15'(i_parts.q100[6:2])
               + 15'(caldc_pkg::f_month_offset(i_parts.date.month))
               - 15'(i_parts.q100);
        wd        = caldc_pkg::f_mod7(wd_sum);
        dim       = caldc_pkg::f_days_in(i_parts.date.month, i_parts.leap);
        after_feb = (i_parts.date.month > caldc_pkg::MONTH_FEB) && i_parts.leap;

        o_word.day_out        = i_parts.date.day;
        o_word.month_out      = i_parts.date.month;
        o_word.year_out       = i_parts.date.year;
        o_word.weekday        = wd;
        o_word.day_of_year    = caldc_pkg::f_days_before(i_parts.date.month)
                              + 9'(i_parts.date.day) + 9'(after_feb);
        o_word.leap_flag      = i_parts.leap;
        o_word.weekend_flag   = (wd == caldc_pkg::WD_FRI) || (wd == caldc_pkg::WD_SAT);
        o_word.month_end_flag = (i_parts.date.day == dim);
        o_word.load_error     = i_parts.err;
    end

endmodule

`default_nettype wire

// File: sv/caldc_checker.sv
`default_nettype none

module caldc_checker (
    input  var logic                 i_clk,
    input  var logic                 i_rst_n,
    input  var logic                 i_out_ready,
    input  var logic                 o_out_valid,
    input  var caldc_pkg::t_out_word o_out_data
);

    // a stalled result word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("output word changed while stalled");

    // the output day is at least 1, and month and year stay within their calendar ranges
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.day_out >= 5'd1) && (o_out_data.month_out >= 4'd1)
            && (o_out_data.month_out <= 4'd12) && (o_out_data.year_out >= 14'd1)
            && (o_out_data.year_out <= 14'd9999))
        else $error("output date out of range");

    // leap years are multiples of four
    a_leap_div4: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.leap_flag |-> (o_out_data.year_out[1:0] == 2'd0))
        else $error("leap flag on a year not divisible by four");

    // a month's last day is never before the 28th, and on it day of year is not below day of month
    a_month_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.month_end_flag |-> (o_out_data.day_out >= 5'd28)
            && (o_out_data.day_of_year >= 9'(o_out_data.day_out)))
        else $error("month end flag inconsistent with date");

endmodule

bind calendar_date_counter caldc_checker u_caldc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_ready (i_out_ready),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data)
);

`default_nettype wire
